>>> rtl/plq_pkg.sv
// Shared types and constants for the price level order queue.
// Used by the controller, the datapath and the top level.
package plq_pkg;

    // Payload widths fixed by the item format
    localparam int ID_W  = 10;
    localparam int VOL_W = 32;
    localparam int SUM_W = 42;

    // Action codes
    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_we;   // clear one in-list entry (post-reset sweep)
        logic load;     // capture an input word, start table read
        logic commit;   // apply the update and load the result word
    } plq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last; // clear sweep is at its last entry
    } plq_status_t;

endpackage

>>> rtl/price_level_order_queue_top.sv
// Top level of the price level order queue: controller plus datapath.
// Depends on plq_pkg, plq_ctrl and plq_datapath.
//
// Keeps the orders at one price level as a doubly linked FIFO in tables
// indexed by order id, with head, tail and running total volume. Each input
// word (append or remove) yields one result word describing the list after
// it; bad_request flags an ignored item (append of a listed order, remove of
// an unlisted one, or an id at or above MAX_ORDERS). The tables are read in
// the accepting cycle and written when the item commits in the lookup state,
// where the result register loads; a new item is taken only after the
// current one has committed. The result register holds a finished word
// while the next item is taken; if that word is still waiting on m_ready
// when the next item is ready to commit, the commit and s_ready wait until
// it is taken. After reset the MAX_ORDERS in-list entries (1024 by default)
// are swept clear with s_ready low.
module price_level_order_queue_top
    import plq_pkg::*;
#(
    parameter int MAX_ORDERS = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [ID_W-1:0]    s_order_id,
    input  logic [VOL_W-1:0]   s_order_volume,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [SUM_W-1:0]   m_total_volume,
    output logic [ID_W-1:0]    m_head_id,
    output logic [ID_W-1:0]    m_tail_id,
    output logic               m_is_empty,
    output logic               m_bad_request
);

    plq_cmd_t    cmd;
    plq_status_t status;

    plq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    plq_datapath #(
        .MAX_ORDERS (MAX_ORDERS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_action       (s_action),
        .s_order_id     (s_order_id),
        .s_order_volume (s_order_volume),
        .m_total_volume (m_total_volume),
        .m_head_id      (m_head_id),
        .m_tail_id      (m_tail_id),
        .m_is_empty     (m_is_empty),
        .m_bad_request  (m_bad_request)
    );

endmodule

>>> rtl/plq_ctrl.sv
// Sequencer for the price level order queue: clear sweep, accept, lookup/commit.
// Depends on plq_pkg for the command and status structs.
module plq_ctrl
    import plq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output plq_cmd_t    cmd,
    input  plq_status_t status
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_full_reg, out_full_next;
    logic       out_free;

    // Result slot is free when empty or when the current word is taken
    assign out_free = !out_full_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_we = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // table read data is ready; wait only for the result slot
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        out_full_next = out_full_reg;
        if (cmd.commit) begin
            out_full_next = 1'b1;
        end else if (m_ready) begin
            out_full_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            out_full_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_full_reg;

endmodule

>>> rtl/plq_datapath.sv
// Datapath of the price level order queue: link/volume/in-list tables,
// head, tail and running total, and the result register. Depends on plq_pkg.
module plq_datapath
    import plq_pkg::*;
#(
    parameter int MAX_ORDERS = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  plq_cmd_t           cmd,
    output plq_status_t        status,
    input  logic               s_action,
    input  logic [ID_W-1:0]    s_order_id,
    input  logic [VOL_W-1:0]   s_order_volume,
    output logic [SUM_W-1:0]   m_total_volume,
    output logic [ID_W-1:0]    m_head_id,
    output logic [ID_W-1:0]    m_tail_id,
    output logic               m_is_empty,
    output logic               m_bad_request
);

    localparam int AW = $clog2(MAX_ORDERS);

    // Tables; an entry is meaningful only while its in-list bit is set
    logic [ID_W-1:0]  prev_link_reg [MAX_ORDERS];
    logic [ID_W-1:0]  next_link_reg [MAX_ORDERS];
    logic [VOL_W-1:0] stored_vol_reg[MAX_ORDERS];
    logic             in_list_reg   [MAX_ORDERS];

    logic [ID_W-1:0]  prev_rd_reg;
    logic [ID_W-1:0]  next_rd_reg;
    logic [VOL_W-1:0] vol_rd_reg;
    logic             valid_rd_reg;

    // Captured input word
    logic             action_reg;
    logic [ID_W-1:0]  id_reg;
    logic [VOL_W-1:0] vol_reg;

    // List state
    logic [ID_W-1:0]  head_reg, head_next;
    logic [ID_W-1:0]  tail_reg, tail_next;
    logic             nonempty_reg, nonempty_next;
    logic [SUM_W-1:0] sum_reg, sum_next;

    logic [AW-1:0]    clr_cnt_reg;

    logic [AW-1:0]    rd_addr;
    logic             in_range;
    logic             is_append;
    logic             has_prev;
    logic             has_next;
    logic             ok;
    logic             apply;

    logic             prev_we;
    logic [AW-1:0]    prev_wa;
    logic [ID_W-1:0]  prev_wd;
    logic             next_we;
    logic [AW-1:0]    next_wa;
    logic [ID_W-1:0]  next_wd;
    logic             valid_we;
    logic [AW-1:0]    valid_wa;
    logic             valid_wd;
    logic             vol_we;

    // Read address: the new word's id on accept, else the captured id
    assign rd_addr = cmd.load ? AW'(s_order_id) : AW'(id_reg);

    // Capture input word
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= s_action;
            id_reg     <= s_order_id;
            vol_reg    <= s_order_volume;
        end
    end

    // Request decode. The head has no predecessor and the tail no successor,
    // so the stored links of those ends are never consulted.
    assign in_range  = (32'(id_reg) < 32'(MAX_ORDERS));
    assign is_append = (action_reg == ACT_APPEND);
    assign has_prev  = (id_reg != head_reg);
    assign has_next  = (id_reg != tail_reg);
    assign ok        = in_range && (is_append ? !valid_rd_reg : valid_rd_reg);
    assign apply     = cmd.commit && ok;

    // List state update
    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        nonempty_next = nonempty_reg;
        sum_next      = sum_reg;
        if (apply) begin
            if (is_append) begin
                if (!nonempty_reg) begin
                    head_next = id_reg;
                end
                tail_next     = id_reg;
                nonempty_next = 1'b1;
                sum_next      = sum_reg + SUM_W'(vol_reg);
            end else begin
                if (!has_prev) begin
                    head_next = has_next ? next_rd_reg : '0;
                end
                if (!has_next) begin
                    tail_next = has_prev ? prev_rd_reg : '0;
                end
                if (!has_prev && !has_next) begin
                    nonempty_next = 1'b0;
                end
                sum_next = sum_reg - SUM_W'(vol_rd_reg);
            end
        end
    end

    // Table writes
    always_comb begin
        prev_we  = apply && (is_append || (has_prev && has_next));
        prev_wa  = is_append ? AW'(id_reg) : AW'(next_rd_reg);
        prev_wd  = is_append ? tail_reg : prev_rd_reg;
        next_we  = apply && (is_append ? nonempty_reg : (has_prev && has_next));
        next_wa  = is_append ? AW'(tail_reg) : AW'(prev_rd_reg);
        next_wd  = is_append ? id_reg : next_rd_reg;
        valid_we = cmd.clr_we || apply;
        valid_wa = cmd.clr_we ? clr_cnt_reg : AW'(id_reg);
        valid_wd = cmd.clr_we ? 1'b0 : is_append;
        vol_we   = apply && is_append;
    end

    always_ff @(posedge aclk) begin
        if (prev_we) begin
            prev_link_reg[prev_wa] <= prev_wd;
        end
        prev_rd_reg <= prev_link_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (next_we) begin
            next_link_reg[next_wa] <= next_wd;
        end
        next_rd_reg <= next_link_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (vol_we) begin
            stored_vol_reg[AW'(id_reg)] <= vol_reg;
        end
        vol_rd_reg <= stored_vol_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (valid_we) begin
            in_list_reg[valid_wa] <= valid_wd;
        end
        valid_rd_reg <= in_list_reg[rd_addr];
    end

    // Post-reset clear sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_we) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    assign status.clr_last = (clr_cnt_reg == AW'(MAX_ORDERS - 1));

    // List state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            nonempty_reg <= 1'b0;
            sum_reg      <= '0;
        end else begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            nonempty_reg <= nonempty_next;
            sum_reg      <= sum_next;
        end
    end

    // Result word
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_total_volume <= sum_next;
            m_head_id      <= head_next;
            m_tail_id      <= tail_next;
            m_is_empty     <= !nonempty_next;
            m_bad_request  <= !ok;
        end
    end

endmodule

>>> rtl/plq_checker.sv
// Port-level checks for the price level order queue, bound to the top level.
// Depends on plq_pkg and price_level_order_queue_top.
module plq_checker
    import plq_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [SUM_W-1:0] m_total_volume,
    input logic [ID_W-1:0]  m_head_id,
    input logic [ID_W-1:0]  m_tail_id,
    input logic             m_is_empty,
    input logic             m_bad_request
);

    // An empty list reports zero head, tail and total
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_empty |->
            (m_head_id == '0) && (m_tail_id == '0) && (m_total_volume == '0))
        else $error("empty list with nonzero head, tail or total");

    // One item at a time: no word taken in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted in lookup cycle");

    // Reset leaves no result pending and input closed during the sweep
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("result or ready asserted out of reset");

    // Stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_volume)
            && $stable(m_head_id) && $stable(m_tail_id)
            && $stable(m_is_empty) && $stable(m_bad_request))
        else $error("result word changed while stalled");

endmodule

bind price_level_order_queue_top plq_checker u_plq_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_total_volume (m_total_volume),
    .m_head_id      (m_head_id),
    .m_tail_id      (m_tail_id),
    .m_is_empty     (m_is_empty),
    .m_bad_request  (m_bad_request)
);
